/* rtl/lcdt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdt_pkg: shared types and constants of the LCD mode and timing registers
// Request and response structs, operation codes, register addresses, mode
// codes and line timing constants.
// ----------------------------------------------------------------------------
package lcdt_pkg;

	// Operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Display modes
	localparam logic [1:0] MODE_HBLANK   = 2'd0;
	localparam logic [1:0] MODE_VBLANK   = 2'd1;
	localparam logic [1:0] MODE_SEARCH   = 2'd2;
	localparam logic [1:0] MODE_TRANSFER = 2'd3;

	// Register addresses
	localparam logic [15:0] ADDR_CONTROL  = 16'hFF40;
	localparam logic [15:0] ADDR_STAT     = 16'hFF41;
	localparam logic [15:0] ADDR_SCROLL_Y = 16'hFF42;
	localparam logic [15:0] ADDR_SCROLL_X = 16'hFF43;
	localparam logic [15:0] ADDR_LINE     = 16'hFF44;
	localparam logic [15:0] ADDR_LINE_CMP = 16'hFF45;
	localparam logic [15:0] ADDR_WINDOW_Y = 16'hFF4A;
	localparam logic [15:0] ADDR_WINDOW_X = 16'hFF4B;
	localparam logic [15:0] ADDR_BG_INDEX = 16'hFF68;
	localparam logic [15:0] ADDR_BG_DATA  = 16'hFF69;
	localparam logic [15:0] ADDR_OBJ_INDEX = 16'hFF6A;
	localparam logic [15:0] ADDR_OBJ_DATA  = 16'hFF6B;

	// Line timing, in cycles from the start of a line, and vblank line numbers
	localparam logic [10:0] SEARCH_END   = 11'd82;
	localparam logic [10:0] TRANSFER_END = 11'd250;
	localparam logic [10:0] LINE_CYCLES  = 11'd456;
	localparam logic [10:0] COUNT_MAX    = 11'd2047;
	localparam logic [7:0]  VBLANK_LINE  = 8'd144;
	localparam logic [7:0]  LAST_LINE    = 8'd153;

	// Stat enable bits
	localparam int EN_HBLANK  = 0;
	localparam int EN_VBLANK  = 1;
	localparam int EN_SEARCH  = 2;
	localparam int EN_COMPARE = 3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [9:0]  cycles;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       line_done;
		logic       render_line;
		logic       lcd_irq;
		logic       vblank_irq;
		logic [1:0] current_mode;
		logic [7:0] current_line;
	} rsp_t;

	// Palette port control from the top level
	typedef struct packed {
		logic       index_we;
		logic       data_we;
		logic [7:0] wdata;
	} pal_req_t;

endpackage

/* rtl/lcdt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdt_ram: generic single write, single read RAM
// One write port and one read port, read data registered. Contents are
// undefined after reset.
// ----------------------------------------------------------------------------
module lcdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/lcdt_palette.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdt_palette: colour palette index register and palette memory
// Holds the index, auto-increments it on a data write when its top bit is
// set, and keeps the read data for the current index ready every cycle.
// ----------------------------------------------------------------------------
module lcdt_palette #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lcdt_pkg::pal_req_t ctl,
	output logic [7:0]        index,
	output logic [7:0]        data
);

	localparam int AW = $clog2(DEPTH);

	logic [7:0]       index_q;
	logic [7:0]       index_d;
	logic [DEPTH-1:0] valid_q;
	logic             byp_q;
	logic [7:0]       byp_data_q;
	logic [7:0]       ram_rdata;
	logic             byp_d;

	// Next index: a write to the index, or the increment after a data write
	always_comb begin
		index_d = index_q;
		if (ctl.index_we) begin
			index_d = ctl.wdata;
		end else if (ctl.data_we && index_q[7]) begin
			index_d = index_q + 8'd1;
		end
	end

	// Read ahead at the index that will hold after this edge
	assign byp_d = ctl.data_we && (index_q[AW-1:0] == index_d[AW-1:0]);

	lcdt_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.data_we),
		.waddr(index_q[AW-1:0]),
		.wdata(ctl.wdata),
		.raddr(index_d[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Hold index, written-entry flags and the same-address bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			valid_q <= '0;
			byp_q   <= 1'b0;
		end else begin
			index_q <= index_d;
			byp_q   <= byp_d;
			if (ctl.data_we) begin
				valid_q[index_q[AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= ctl.wdata;
	end

	// Unwritten entries read as zero
	always_comb begin
		if (byp_q) begin
			data = byp_data_q;
		end else if (valid_q[index_q[AW-1:0]]) begin
			data = ram_rdata;
		end else begin
			data = '0;
		end
	end

	assign index = index_q;

endmodule

/* rtl/lcd_mode_timing_registers.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_mode_timing_registers: LCD mode and line timing with bus registers
// Each request is a tick, a register read or a register write; each gives
// exactly one response with the read byte, event strobes and mode and line.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req / req_valid / req_stall, responses leave on
//   rsp / rsp_valid / rsp_stall. A transfer happens on a rising edge where
//   valid is high and stall is low.
//   A request is registered on acceptance and evaluated against the register
//   state while it waits there; the response is registered when the
//   evaluation stage advances, which needs a free response slot.
//   Throughput is one request per cycle while no waiting response is held by
//   rsp_stall; the register state is updated in the same cycle the response is
//   formed, so the next request sees it.
//   Palette reads are served from a RAM whose read is issued ahead, at the
//   index that the previous request leaves behind.
//   When rsp_stall holds a waiting response, the evaluation stage holds too
//   and req_stall rises once that stage is occupied.
//   Reset clears the register state, valid flags and palette indices, sets search mode and marks every palette
//   entry as unwritten (reads zero); there is no clearing pass.
// ----------------------------------------------------------------------------
module lcd_mode_timing_registers #(
	parameter int PALETTE_BYTES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lcdt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lcdt_pkg::rsp_t rsp
);

	// Input stage
	lcdt_pkg::req_t req_s1;
	logic           valid_s1;
	logic           adv;

	// Register state
	logic [7:0]  control_q;
	logic [3:0]  stat_en_q;
	logic [1:0]  mode_q;
	logic        coin_q;
	logic [10:0] count_q;
	logic [7:0]  line_q;
	logic [7:0]  line_cmp_q;
	logic [7:0]  scroll_y_q;
	logic [7:0]  scroll_x_q;
	logic [7:0]  window_y_q;
	logic [7:0]  window_x_q;

	logic [7:0]  control_d;
	logic [3:0]  stat_en_d;
	logic [1:0]  mode_d;
	logic        coin_d;
	logic [10:0] count_d;
	logic [7:0]  line_d;
	logic [7:0]  line_cmp_d;
	logic [7:0]  scroll_y_d;
	logic [7:0]  scroll_x_d;
	logic [7:0]  window_y_d;
	logic [7:0]  window_x_d;

	logic [11:0] sum;
	logic [10:0] count_sat;
	logic [7:0]  line_inc;

	// Response register
	lcdt_pkg::rsp_t rsp_d;
	lcdt_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	// Palettes
	lcdt_pkg::pal_req_t bg_ctl;
	lcdt_pkg::pal_req_t obj_ctl;
	logic [7:0]         bg_index;
	logic [7:0]         bg_data;
	logic [7:0]         obj_index;
	logic [7:0]         obj_data;

	logic is_write;

	// Advance the evaluation stage when the response slot is free
	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;

	// Hold the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// Palette port control
	assign is_write = adv && (req_s1.operation == lcdt_pkg::OP_WRITE);

	always_comb begin
		bg_ctl.index_we  = is_write && (req_s1.address == lcdt_pkg::ADDR_BG_INDEX);
		bg_ctl.data_we   = is_write && (req_s1.address == lcdt_pkg::ADDR_BG_DATA);
		bg_ctl.wdata     = req_s1.write_data;
		obj_ctl.index_we = is_write && (req_s1.address == lcdt_pkg::ADDR_OBJ_INDEX);
		obj_ctl.data_we  = is_write && (req_s1.address == lcdt_pkg::ADDR_OBJ_DATA);
		obj_ctl.wdata    = req_s1.write_data;
	end

	lcdt_palette #(
		.DEPTH(PALETTE_BYTES)
	) u_bg_palette (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (bg_ctl),
		.index (bg_index),
		.data  (bg_data)
	);

	lcdt_palette #(
		.DEPTH(PALETTE_BYTES)
	) u_obj_palette (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (obj_ctl),
		.index (obj_index),
		.data  (obj_data)
	);

	// Saturating cycle count and next line number
	assign sum       = {1'b0, count_q} + {2'b00, req_s1.cycles};
	assign count_sat = sum[11] ? lcdt_pkg::COUNT_MAX : sum[10:0];
	assign line_inc  = line_q + 8'd1;

	// Evaluate the request against the register state
	always_comb begin
		control_d  = control_q;
		stat_en_d  = stat_en_q;
		mode_d     = mode_q;
		coin_d     = coin_q;
		count_d    = count_q;
		line_d     = line_q;
		line_cmp_d = line_cmp_q;
		scroll_y_d = scroll_y_q;
		scroll_x_d = scroll_x_q;
		window_y_d = window_y_q;
		window_x_d = window_x_q;
		rsp_d      = '0;

		unique case (req_s1.operation)
			lcdt_pkg::OP_READ: begin
				unique case (req_s1.address)
					lcdt_pkg::ADDR_CONTROL:   rsp_d.read_data = control_q;
					lcdt_pkg::ADDR_STAT:
						rsp_d.read_data = {1'b0, stat_en_q, coin_q, mode_q};
					lcdt_pkg::ADDR_SCROLL_Y:  rsp_d.read_data = scroll_y_q;
					lcdt_pkg::ADDR_SCROLL_X:  rsp_d.read_data = scroll_x_q;
					lcdt_pkg::ADDR_LINE:      rsp_d.read_data = line_q;
					lcdt_pkg::ADDR_LINE_CMP:  rsp_d.read_data = line_cmp_q;
					lcdt_pkg::ADDR_WINDOW_Y:  rsp_d.read_data = window_y_q;
					lcdt_pkg::ADDR_WINDOW_X:  rsp_d.read_data = window_x_q;
					lcdt_pkg::ADDR_BG_INDEX:  rsp_d.read_data = bg_index;
					lcdt_pkg::ADDR_BG_DATA:   rsp_d.read_data = bg_data;
					lcdt_pkg::ADDR_OBJ_INDEX: rsp_d.read_data = obj_index;
					lcdt_pkg::ADDR_OBJ_DATA:  rsp_d.read_data = obj_data;
					default:                  rsp_d.read_data = '0;
				endcase
			end
			lcdt_pkg::OP_WRITE: begin
				unique case (req_s1.address)
					lcdt_pkg::ADDR_CONTROL:  control_d  = req_s1.write_data;
					lcdt_pkg::ADDR_STAT:     stat_en_d  = req_s1.write_data[6:3];
					lcdt_pkg::ADDR_SCROLL_Y: scroll_y_d = req_s1.write_data;
					lcdt_pkg::ADDR_SCROLL_X: scroll_x_d = req_s1.write_data;
					lcdt_pkg::ADDR_LINE:     line_d     = '0;
					lcdt_pkg::ADDR_LINE_CMP: line_cmp_d = req_s1.write_data;
					lcdt_pkg::ADDR_WINDOW_Y: window_y_d = req_s1.write_data;
					lcdt_pkg::ADDR_WINDOW_X: window_x_d = req_s1.write_data;
					default: ;
				endcase
			end
			lcdt_pkg::OP_TICK: begin
				if (control_q[7]) begin
					count_d = count_sat;
					priority if (mode_q == lcdt_pkg::MODE_SEARCH) begin
						if (count_sat >= lcdt_pkg::SEARCH_END) begin
							mode_d = lcdt_pkg::MODE_TRANSFER;
						end
					end else if (mode_q == lcdt_pkg::MODE_TRANSFER) begin
						if (count_sat >= lcdt_pkg::TRANSFER_END) begin
							mode_d            = lcdt_pkg::MODE_HBLANK;
							rsp_d.lcd_irq     = stat_en_q[lcdt_pkg::EN_HBLANK];
							rsp_d.render_line = 1'b1;
						end
					end else begin
						if (count_sat >= lcdt_pkg::LINE_CYCLES) begin
							count_d         = count_sat - lcdt_pkg::LINE_CYCLES;
							rsp_d.line_done = 1'b1;
							line_d          = line_inc;
							priority if (line_inc < lcdt_pkg::VBLANK_LINE) begin
								mode_d        = lcdt_pkg::MODE_SEARCH;
								rsp_d.lcd_irq = stat_en_q[lcdt_pkg::EN_SEARCH];
							end else if (line_inc == lcdt_pkg::VBLANK_LINE) begin
								mode_d           = lcdt_pkg::MODE_VBLANK;
								rsp_d.lcd_irq    = stat_en_q[lcdt_pkg::EN_VBLANK];
								rsp_d.vblank_irq = 1'b1;
							end else if (line_inc > lcdt_pkg::LAST_LINE) begin
								line_d = '0;
								mode_d = lcdt_pkg::MODE_SEARCH;
							end else begin
								mode_d = mode_q;
							end
							coin_d = (line_d == line_cmp_q);
							if (coin_d && stat_en_q[lcdt_pkg::EN_COMPARE]) begin
								rsp_d.lcd_irq = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase

		rsp_d.current_mode = mode_d;
		rsp_d.current_line = line_d;
	end

	// Update register state and the response slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q   <= '0;
			stat_en_q   <= '0;
			mode_q      <= lcdt_pkg::MODE_SEARCH;
			coin_q      <= 1'b0;
			count_q     <= '0;
			line_q      <= '0;
			line_cmp_q  <= '0;
			scroll_y_q  <= '0;
			scroll_x_q  <= '0;
			window_y_q  <= '0;
			window_x_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				control_q  <= control_d;
				stat_en_q  <= stat_en_d;
				mode_q     <= mode_d;
				coin_q     <= coin_d;
				count_q    <= count_d;
				line_q     <= line_d;
				line_cmp_q <= line_cmp_d;
				scroll_y_q <= scroll_y_d;
				scroll_x_q <= scroll_x_d;
				window_y_q <= window_y_d;
				window_x_q <= window_x_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Vertical blank request only on entry to line 144 in vblank mode
	a_vblank_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.vblank_irq |->
			rsp_q.current_line == lcdt_pkg::VBLANK_LINE &&
			rsp_q.current_mode == lcdt_pkg::MODE_VBLANK)
		else $error("vblank request outside vblank entry");

	// End of transfer leaves hblank mode
	a_render_hblank: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.render_line |->
			rsp_q.current_mode == lcdt_pkg::MODE_HBLANK && !rsp_q.line_done)
		else $error("render strobe without hblank");

	// Event strobes come only from ticks, which return no read data
	a_flags_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_q.line_done || rsp_q.render_line ||
			rsp_q.lcd_irq || rsp_q.vblank_irq) |-> rsp_q.read_data == 8'd0)
		else $error("event strobe with read data");

	// An evaluated request always lands in the response slot
	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> rsp_valid_q)
		else $error("response lost");

endmodule
